// ----- hdl/sos_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants of the stepper oscillation sequencer.
// No dependencies; imported by sos_core, the top level and the testbench.
package sos_pkg;

	localparam int CENTER_W = 20;
	localparam int AMP_W    = 19;
	localparam int JOG_W    = 16;
	localparam int REG_W    = 32;
	localparam int ADDR_W   = 4;

	typedef enum logic [1:0] {
		MODE_IDLE = 2'd0,
		MODE_OSC  = 2'd1,
		MODE_RET  = 2'd2,
		MODE_JOG  = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		CMD_TICK = 2'd0,
		CMD_OSC  = 2'd1,
		CMD_STOP = 2'd2,
		CMD_JOG  = 2'd3
	} cmd_t;

	localparam logic [1:0] REG_STEP_INTERVAL = 2'd0;
	localparam logic [1:0] REG_PHASE_DELAY   = 2'd1;
	localparam logic [1:0] REG_CENTER_OFFSET = 2'd2;
	localparam logic [1:0] REG_SWING_AMP     = 2'd3;

	localparam logic [REG_W-1:0] STEP_INTERVAL_RST = 32'd1000;

	typedef struct packed {
		logic [REG_W-1:0]    step_interval;
		logic [REG_W-1:0]    phase_delay;
		logic [CENTER_W-1:0] center_offset;
		logic [AMP_W-1:0]    swing_amplitude;
	} cfg_t;

	typedef struct packed {
		cmd_t             cmd;
		logic [JOG_W-1:0] jog_count;
		logic             jog_up;
	} item_t;

endpackage

// ----- hdl/stepper_oscillation_sequencer_unit.sv -----
`timescale 1ns / 1ps
// Stepper oscillation sequencer, top level: APB registers, input stage,
// tick state and result register. Depends on sos_pkg and sos_core.
// out_valid follows an input transfer through the input stage and the result register; out_stall can hold either.
// Throughput: one tick per cycle while out_stall is low; sos_core computes the next state combinationally.
// Reset (arst_n low): registers to defaults, idle, position 0, direction up, timer unarmed.
module stepper_oscillation_sequencer_unit #(
	parameter int POS_WIDTH   = 20,
	parameter int TIMER_WIDTH = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [sos_pkg::ADDR_W-1:0]     paddr,
	input  logic [sos_pkg::REG_W-1:0]      pwdata,
	output logic [sos_pkg::REG_W-1:0]      prdata,
	output logic                           pready,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [1:0]                     cmd,
	input  logic [sos_pkg::JOG_W-1:0]      jog_count,
	input  logic                           jog_up,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic                           step_pulse,
	output logic                           dir_out,
	output logic [POS_WIDTH-1:0]           position_now,
	output logic [1:0]                     mode_now
);
	import sos_pkg::*;

	cfg_t                   cfg_q;
	item_t                  item_s1;
	logic                   valid_s1, valid_s2, advance, wr_en;
	mode_t                  mode_q, mode_d;
	logic [POS_WIDTH-1:0]   pos_q, pos_d, pos_s2;
	logic                   up_q, up_d, armed_q, armed_d, pulse, pulse_s2, up_s2;
	logic [TIMER_WIDTH:0]   elapsed_q, elapsed_d;
	logic [JOG_W-1:0]       jog_left_q, jog_left_d;
	mode_t                  mode_s2;

	// configuration port
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.step_interval   <= STEP_INTERVAL_RST;
			cfg_q.phase_delay     <= '0;
			cfg_q.center_offset   <= '0;
			cfg_q.swing_amplitude <= '0;
		end else if (wr_en) begin
			case (paddr[3:2])
				REG_STEP_INTERVAL: cfg_q.step_interval   <= pwdata;
				REG_PHASE_DELAY:   cfg_q.phase_delay     <= pwdata;
				REG_CENTER_OFFSET: cfg_q.center_offset   <= pwdata[CENTER_W-1:0];
				REG_SWING_AMP:     cfg_q.swing_amplitude <= pwdata[AMP_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_STEP_INTERVAL: prdata = cfg_q.step_interval;
			REG_PHASE_DELAY:   prdata = cfg_q.phase_delay;
			REG_CENTER_OFFSET: prdata = {{(REG_W-CENTER_W){1'b0}}, cfg_q.center_offset};
			REG_SWING_AMP:     prdata = {{(REG_W-AMP_W){1'b0}}, cfg_q.swing_amplitude};
			default:           prdata = '0;
		endcase
	end

	// handshake
	assign advance  = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (!in_stall)
				valid_s1 <= in_valid;
			if (advance)
				valid_s2 <= 1'b1;
			else if (!out_stall)
				valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1.cmd       <= cmd_t'(cmd);
			item_s1.jog_count <= jog_count;
			item_s1.jog_up    <= jog_up;
		end
	end

	sos_core #(
		.POS_WIDTH  (POS_WIDTH),
		.TIMER_WIDTH(TIMER_WIDTH)
	) u_core (
		.cfg       (cfg_q),
		.item      (item_s1),
		.mode_q    (mode_q),
		.pos_q     (pos_q),
		.up_q      (up_q),
		.armed_q   (armed_q),
		.elapsed_q (elapsed_q),
		.jog_left_q(jog_left_q),
		.mode_d    (mode_d),
		.pos_d     (pos_d),
		.up_d      (up_d),
		.armed_d   (armed_d),
		.elapsed_d (elapsed_d),
		.jog_left_d(jog_left_d),
		.pulse     (pulse)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_IDLE;
			pos_q      <= '0;
			up_q       <= 1'b1;
			armed_q    <= 1'b0;
			elapsed_q  <= '0;
			jog_left_q <= '0;
		end else if (advance) begin
			mode_q     <= mode_d;
			pos_q      <= pos_d;
			up_q       <= up_d;
			armed_q    <= armed_d;
			elapsed_q  <= elapsed_d;
			jog_left_q <= jog_left_d;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (advance) begin
			pulse_s2 <= pulse;
			up_s2    <= up_d;
			pos_s2   <= pos_d;
			mode_s2  <= mode_d;
		end
	end

	assign out_valid    = valid_s2;
	assign step_pulse   = pulse_s2;
	assign dir_out      = up_s2;
	assign position_now = pos_s2;
	assign mode_now     = mode_s2;

	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> valid_s1)
		else $error("input stage dropped a stalled transfer");

	a_result: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> valid_s2)
		else $error("processed tick produced no result");

	a_unarmed: assert property (@(posedge clk) disable iff (!arst_n)
		!armed_q |-> (elapsed_q == '0))
		else $error("elapsed count runs while timer unarmed");

	a_arm: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && pulse && mode_d != MODE_IDLE) |=> armed_q)
		else $error("step issued without arming timer");

endmodule

// ----- hdl/sos_core.sv -----
`timescale 1ns / 1ps
// Next-state logic for one tick: command decode, step timer, position update.
// Depends on sos_pkg.
module sos_core #(
	parameter int POS_WIDTH   = 20,
	parameter int TIMER_WIDTH = 32
) (
	input  sos_pkg::cfg_t                 cfg,
	input  sos_pkg::item_t                item,
	input  sos_pkg::mode_t                mode_q,
	input  logic [POS_WIDTH-1:0]          pos_q,
	input  logic                          up_q,
	input  logic                          armed_q,
	input  logic [TIMER_WIDTH:0]          elapsed_q,
	input  logic [sos_pkg::JOG_W-1:0]     jog_left_q,
	output sos_pkg::mode_t                mode_d,
	output logic [POS_WIDTH-1:0]          pos_d,
	output logic                          up_d,
	output logic                          armed_d,
	output logic [TIMER_WIDTH:0]          elapsed_d,
	output logic [sos_pkg::JOG_W-1:0]     jog_left_d,
	output logic                          pulse
);
	import sos_pkg::*;

	localparam int EW = TIMER_WIDTH + 1;
	localparam int WW = ((POS_WIDTH > CENTER_W) ? POS_WIDTH : CENTER_W) + 2;
	localparam logic [POS_WIDTH-1:0] PMAX = {1'b0, {(POS_WIDTH-1){1'b1}}};
	localparam logic [POS_WIDTH-1:0] PMIN = ~PMAX;
	localparam logic signed [WW-1:0] PMAX_W = {{(WW-POS_WIDTH+1){1'b0}}, {(POS_WIDTH-1){1'b1}}};
	localparam logic signed [WW-1:0] PMIN_W = ~PMAX_W;

	function automatic logic signed [WW-1:0] ext_pos(input logic [POS_WIDTH-1:0] p);
		return $signed({{(WW-POS_WIDTH){p[POS_WIDTH-1]}}, p});
	endfunction

	logic [TIMER_WIDTH+REG_W-1:0] si_x, pd_x;
	logic [TIMER_WIDTH-1:0]       pd_t;
	logic [EW-1:0]                thr, el_inc, el_c;
	mode_t                        mode_c;
	logic [POS_WIDTH-1:0]         pos_c, pos_mv, tgt;
	logic                         up_c, up_mv, armed_c, want, ret_done;
	logic [JOG_W-1:0]             jl_c;
	logic signed [WW-1:0]         ctr_w, half_w, hi_w, lo_w, tgt_w;

	// timing registers used in their low TIMER_WIDTH bits
	assign si_x = {{TIMER_WIDTH{1'b0}}, cfg.step_interval};
	assign pd_x = {{TIMER_WIDTH{1'b0}}, cfg.phase_delay};
	assign pd_t = pd_x[TIMER_WIDTH-1:0];
	assign thr  = {1'b0, si_x[TIMER_WIDTH-1:0]} + {1'b0, pd_t};

	assign el_inc = (armed_q && elapsed_q != '1) ? elapsed_q + EW'(1) : elapsed_q;

	// command
	always_comb begin
		mode_c  = mode_q;
		pos_c   = pos_q;
		up_c    = up_q;
		armed_c = armed_q;
		el_c    = el_inc;
		jl_c    = jog_left_q;
		case (item.cmd)
			CMD_OSC: begin
				mode_c = MODE_OSC;
				if (!armed_q) begin
					armed_c = 1'b1;
					el_c    = '0;
				end
			end
			CMD_STOP: mode_c = MODE_RET;
			CMD_JOG: begin
				mode_c = MODE_JOG;
				pos_c  = '0;
				up_c   = item.jog_up;
				jl_c   = item.jog_count;
			end
			default: ;
		endcase
	end

	// bounds and return target
	always_comb begin
		ctr_w  = $signed({{(WW-CENTER_W){cfg.center_offset[CENTER_W-1]}}, cfg.center_offset});
		half_w = $signed({{(WW-AMP_W+1){1'b0}}, cfg.swing_amplitude[AMP_W-1:1]});
		hi_w   = ctr_w + half_w;
		lo_w   = ctr_w - half_w;
		if (ctr_w > PMAX_W)
			tgt_w = PMAX_W;
		else if (ctr_w < PMIN_W)
			tgt_w = PMIN_W;
		else
			tgt_w = ctr_w;
		tgt = tgt_w[POS_WIDTH-1:0];
	end

	always_comb begin
		case (mode_c)
			MODE_OSC: want = 1'b1;
			MODE_RET: want = (pos_c != tgt);
			MODE_JOG: want = (jl_c != '0);
			default:  want = 1'b0;
		endcase
	end

	assign pulse = want && (!armed_c || el_c > thr);

	// step and direction
	always_comb begin
		pos_mv     = pos_c;
		up_mv      = up_c;
		jog_left_d = jl_c;
		case (mode_c)
			MODE_OSC: begin
				if (up_c) begin
					if (pulse && pos_c != PMAX)
						pos_mv = pos_c + POS_WIDTH'(1);
					if (ext_pos(pos_mv) >= hi_w || pos_mv == PMAX)
						up_mv = 1'b0;
				end else begin
					if (pulse && pos_c != PMIN)
						pos_mv = pos_c - POS_WIDTH'(1);
					if (ext_pos(pos_mv) <= lo_w || pos_mv == PMIN)
						up_mv = 1'b1;
				end
			end
			MODE_RET: begin
				if (pos_c != tgt) begin
					up_mv = ext_pos(pos_c) < tgt_w;
					if (pulse)
						pos_mv = up_mv ? pos_c + POS_WIDTH'(1) : pos_c - POS_WIDTH'(1);
				end
			end
			MODE_JOG: begin
				if (pulse) begin
					if (pos_c != PMAX)
						pos_mv = pos_c + POS_WIDTH'(1);
					jog_left_d = jl_c - JOG_W'(1);
				end
			end
			default: ;
		endcase
	end

	assign ret_done = (mode_c == MODE_RET) && (pos_mv == tgt);

	always_comb begin
		pos_d     = ret_done ? '0 : pos_mv;
		up_d      = ret_done ? 1'b1 : up_mv;
		armed_d   = ret_done ? 1'b0 : (pulse ? 1'b1 : armed_c);
		elapsed_d = ret_done ? '0 : (pulse ? {1'b0, pd_t} : el_c);
	end

	// mode next state
	always_comb begin
		case (mode_c)
			MODE_RET: mode_d = ret_done ? MODE_IDLE : MODE_RET;
			MODE_JOG: mode_d = (jog_left_d == '0) ? MODE_IDLE : MODE_JOG;
			default:  mode_d = mode_c;
		endcase
	end

endmodule

// ----- tb/tb_stepper_oscillation_sequencer_unit.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for stepper_oscillation_sequencer_unit: sends ticks and
// commands, predicts each tick's step, direction, position and mode, checks every transfer.
// Depends on sos_pkg and the top level RTL; needs no files or arguments.
module tb_stepper_oscillation_sequencer_unit;
	import sos_pkg::*;

	localparam int POS_W = 20;
	localparam longint POS_HI = 524287;
	localparam longint POS_LO = -524288;
	localparam int QUIET_LIMIT = 2000;

	typedef struct {
		bit              pulse;
		bit              dir;
		logic [POS_W-1:0] pos;
		mode_t           mode;
	} motion_t;

	logic                clk;
	logic                arst_n;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [ADDR_W-1:0]   paddr;
	logic [REG_W-1:0]    pwdata;
	logic [REG_W-1:0]    prdata;
	logic                pready;
	logic                in_valid;
	logic                in_stall;
	logic [1:0]          cmd;
	logic [JOG_W-1:0]    jog_count;
	logic                jog_up;
	logic                out_valid;
	logic                out_stall;
	logic                step_pulse;
	logic                dir_out;
	logic [POS_W-1:0]    position_now;
	logic [1:0]          mode_now;

	stepper_oscillation_sequencer_unit #(.POS_WIDTH(POS_W), .TIMER_WIDTH(32)) dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_stall(in_stall),
		.cmd(cmd), .jog_count(jog_count), .jog_up(jog_up),
		.out_valid(out_valid), .out_stall(out_stall),
		.step_pulse(step_pulse), .dir_out(dir_out),
		.position_now(position_now), .mode_now(mode_now)
	);

	// predicted motor state and register copies
	logic [31:0]        cfg_interval;
	logic [31:0]        cfg_phase;
	logic signed [19:0] cfg_center;
	logic [18:0]        cfg_amp;
	mode_t              m_mode;
	longint             m_pos;
	bit                 m_up;
	bit                 m_armed;
	logic [32:0]        m_elapsed;
	logic [15:0]        m_jog_left;

	motion_t pending_motion[$];
	motion_t seen;
	int      bad_fields = 0;
	int      quiet = 0;
	int      hold_len = 0;
	bit      stall_tx = 1'b0;
	bit      stall_rx = 1'b0;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	task automatic flag_mismatch(string what, longint got, longint want);
		bad_fields++;
		if (bad_fields <= 60)
			$display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
	endtask

	function automatic longint clamp_pos(longint v);
		if (v > POS_HI)
			return POS_HI;
		if (v < POS_LO)
			return POS_LO;
		return v;
	endfunction

	function bit fire_timer();
		logic [32:0] thr;
		thr = {1'b0, cfg_interval} + {1'b0, cfg_phase};
		if (!m_armed || m_elapsed > thr) begin
			m_armed = 1'b1;
			m_elapsed = {1'b0, cfg_phase};
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function motion_t advance_motor(cmd_t c, logic [15:0] n, logic u);
		motion_t r;
		longint  ctr;
		longint  half;
		longint  tgt;
		r.pulse = 1'b0;
		ctr = longint'(cfg_center);
		half = longint'(cfg_amp / 2);
		if (m_armed && m_elapsed != '1)
			m_elapsed = m_elapsed + 1'b1;
		case (c)
			CMD_OSC: begin
				m_mode = MODE_OSC;
				if (!m_armed) begin
					m_armed = 1'b1;
					m_elapsed = '0;
				end
			end
			CMD_STOP: m_mode = MODE_RET;
			CMD_JOG: begin
				m_mode = MODE_JOG;
				m_pos = 0;
				m_up = u;
				m_jog_left = n;
			end
			default: ;
		endcase
		case (m_mode)
			MODE_OSC: begin
				if (m_up) begin
					if (fire_timer()) begin
						r.pulse = 1'b1;
						m_pos = clamp_pos(m_pos + 1);
					end
					if (m_pos >= ctr + half || m_pos == POS_HI)
						m_up = 1'b0;
				end else begin
					if (fire_timer()) begin
						r.pulse = 1'b1;
						m_pos = clamp_pos(m_pos - 1);
					end
					if (m_pos <= ctr - half || m_pos == POS_LO)
						m_up = 1'b1;
				end
			end
			MODE_RET: begin
				tgt = clamp_pos(ctr);
				if (m_pos != tgt) begin
					m_up = m_pos < tgt;
					if (fire_timer()) begin
						r.pulse = 1'b1;
						m_pos = m_up ? m_pos + 1 : m_pos - 1;
					end
				end
				if (m_pos == tgt) begin
					m_pos = 0;
					m_up = 1'b1;
					m_armed = 1'b0;
					m_elapsed = '0;
					m_mode = MODE_IDLE;
				end
			end
			MODE_JOG: begin
				if (m_jog_left != 0) begin
					if (fire_timer()) begin
						r.pulse = 1'b1;
						m_pos = clamp_pos(m_pos + 1);
						m_jog_left = m_jog_left - 1'b1;
					end
				end
				if (m_jog_left == 0)
					m_mode = MODE_IDLE;
			end
			default: ;
		endcase
		r.dir = m_up;
		r.pos = m_pos[POS_W-1:0];
		r.mode = m_mode;
		return r;
	endfunction

	// one transfer on the tick channel, predicted as it is accepted
	task automatic send_item(cmd_t c, logic [15:0] n, logic u);
		int gap;
		bit took;
		gap = stall_tx ? $urandom_range(0, 6) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= c;
		jog_count <= n;
		jog_up <= u;
		do begin
			@(negedge clk);
			took = !in_stall;
			@(posedge clk);
		end while (!took);
		pending_motion.push_back(advance_motor(c, n, u));
	endtask

	task automatic send_tick(int count);
		repeat (count) send_item(CMD_TICK, 16'($urandom), 1'($urandom));
	endtask

	task automatic send_random(int count);
		cmd_t        c;
		logic [15:0] n;
		int          pick;
		repeat (count) begin
			pick = $urandom_range(0, 99);
			if (pick < 78)
				c = CMD_TICK;
			else if (pick < 86)
				c = CMD_OSC;
			else if (pick < 93)
				c = CMD_STOP;
			else
				c = CMD_JOG;
			n = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 12));
			send_item(c, n, 1'($urandom));
		end
	endtask

	// drop valid and wait until every predicted transfer has come back
	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_motion.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [31:0] v);
		logic [31:0] rd;
		logic [31:0] mask;
		bit          rdy;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		do begin
			@(negedge clk);
			rdy = pready;
			@(posedge clk);
		end while (!rdy);
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do begin
			@(negedge clk);
			rdy = pready;
			rd = prdata;
			@(posedge clk);
		end while (!rdy);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_STEP_INTERVAL: begin
				cfg_interval = v;
				mask = 32'hFFFF_FFFF;
			end
			REG_PHASE_DELAY: begin
				cfg_phase = v;
				mask = 32'hFFFF_FFFF;
			end
			REG_CENTER_OFFSET: begin
				cfg_center = v[19:0];
				mask = 32'h000F_FFFF;
			end
			default: begin
				cfg_amp = v[18:0];
				mask = 32'h0007_FFFF;
			end
		endcase
		if ((rd & mask) != (v & mask))
			flag_mismatch("register readback", longint'(rd & mask), longint'(v & mask));
	endtask

	task automatic setup_motion(logic [31:0] iv, logic [31:0] ph, logic [19:0] ctr,
			logic [18:0] amp);
		write_reg(REG_STEP_INTERVAL, iv);
		write_reg(REG_PHASE_DELAY, ph);
		write_reg(REG_CENTER_OFFSET, {12'd0, ctr});
		write_reg(REG_SWING_AMP, {13'd0, amp});
	endtask

	// reset registers: unarmed timer fires at once, zero jog, stop when already at center
	task automatic test_reset_defaults();
		send_item(CMD_TICK, 16'd0, 1'b0);
		send_item(CMD_JOG, 16'd1, 1'b1);
		send_item(CMD_TICK, 16'hFFFF, 1'b1);
		send_item(CMD_STOP, 16'd0, 1'b0);
		send_item(CMD_JOG, 16'd0, 1'b0);
		send_item(CMD_STOP, 16'd0, 1'b0);
		drain_results();
	endtask

	// odd amplitude, so the half swing rounds down; reversal at the upper bound
	task automatic test_oscillation_reversal();
		setup_motion(32'd1, 32'd0, 20'd0, 19'd5);
		send_item(CMD_OSC, 16'd0, 1'b0);
		send_tick(9);
		send_item(CMD_STOP, 16'd0, 1'b0);
		send_tick(3);
		drain_results();
	endtask

	task automatic test_jog_extremes();
		send_item(CMD_JOG, 16'hFFFF, 1'b0);
		send_tick(2);
		send_item(CMD_STOP, 16'hFFFF, 1'b1);
		send_tick(2);
		send_item(CMD_JOG, 16'h8000, 1'b1);
		send_item(CMD_OSC, 16'h7FFF, 1'b0);
		drain_results();
	endtask

	task automatic test_register_extremes();
		setup_motion(32'hFFFF_FFFF, 32'hFFFF_FFFF, 20'h80000, 19'h7FFFF);
		send_item(CMD_OSC, 16'd0, 1'b0);
		send_tick(3);
		send_item(CMD_STOP, 16'd0, 1'b0);
		send_tick(2);
		drain_results();
		setup_motion(32'd1, 32'd0, 20'h7FFFF, 19'd0);
		send_item(CMD_OSC, 16'd0, 1'b0);
		send_tick(5);
		send_item(CMD_JOG, 16'd0, 1'b1);
		drain_results();
		setup_motion(32'd3, 32'd2, 20'd0, 19'd1);
		send_item(CMD_OSC, 16'd0, 1'b1);
		send_tick(20);
		send_item(CMD_STOP, 16'd0, 1'b0);
		send_tick(10);
		drain_results();
	endtask

	// center moved while returning
	task automatic test_moving_center();
		setup_motion(32'd1, 32'd0, 20'd0, 19'd10);
		send_item(CMD_OSC, 16'd0, 1'b0);
		send_tick(8);
		send_item(CMD_STOP, 16'd0, 1'b0);
		send_tick(2);
		drain_results();
		write_reg(REG_CENTER_OFFSET, 32'd3);
		send_tick(12);
		drain_results();
		write_reg(REG_CENTER_OFFSET, 32'h000F_FFFE);
		send_item(CMD_JOG, 16'd4, 1'b1);
		send_tick(8);
		send_item(CMD_STOP, 16'd0, 1'b0);
		send_tick(14);
		drain_results();
	endtask

	// receiver holds off long enough that the block stalls its input
	task automatic test_backpressure();
		setup_motion(32'd2, 32'd1, 20'hFFFFB, 19'd14);
		stall_tx = 1'b0;
		stall_rx = 1'b0;
		hold_len = 60;
		send_item(CMD_OSC, 16'd0, 1'b1);
		send_random(80);
		drain_results();
	endtask

	task automatic test_pause_drain();
		stall_tx = 1'b1;
		stall_rx = 1'b1;
		send_random(20);
		drain_results();
		send_random(20);
		drain_results();
	endtask

	task automatic test_random_phases();
		logic [31:0] iv;
		logic [31:0] ph;
		logic [19:0] ctr;
		logic [18:0] amp;
		repeat (8) begin
			iv = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(1, 4);
			if (iv == 0)
				iv = 1;
			ph = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 3);
			ctr = ($urandom_range(0, 5) == 0) ? 20'($urandom) : 20'($urandom_range(0, 40) - 20);
			amp = ($urandom_range(0, 5) == 0) ? 19'($urandom) : 19'($urandom_range(0, 24));
			setup_motion(iv, ph, ctr, amp);
			stall_tx = $urandom_range(0, 2) != 0;
			stall_rx = $urandom_range(0, 2) != 0;
			send_random(100);
			drain_results();
		end
	endtask

	initial begin : receiver
		int wait_n;
		bit took;
		forever begin
			if (hold_len > 0) begin
				out_stall <= 1'b1;
				repeat (hold_len) @(posedge clk);
				hold_len = 0;
			end
			wait_n = stall_rx ? $urandom_range(0, 6) : 0;
			if (wait_n > 0) begin
				out_stall <= 1'b1;
				repeat (wait_n) @(posedge clk);
			end
			out_stall <= 1'b0;
			do begin
				@(negedge clk);
				took = out_valid && arst_n;
				@(posedge clk);
			end while (!took);
		end
	end

	// payload is stable at the falling edge ahead of the transfer edge
	always @(negedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_motion.size() == 0) begin
				flag_mismatch("transfer with nothing pending", longint'(mode_now), -1);
			end else begin
				seen = pending_motion.pop_front();
				if (step_pulse !== seen.pulse)
					flag_mismatch("step_pulse", longint'(step_pulse), longint'(seen.pulse));
				if (dir_out !== seen.dir)
					flag_mismatch("dir_out", longint'(dir_out), longint'(seen.dir));
				if (position_now !== seen.pos)
					flag_mismatch("position_now", longint'($signed(position_now)),
						longint'($signed(seen.pos)));
				if (mode_now !== seen.mode)
					flag_mismatch("mode_now", longint'(mode_now), longint'(seen.mode));
			end
		end
	end

	always @(negedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet = 0;
		end else begin
			quiet++;
			if (quiet >= QUIET_LIMIT) begin
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	initial begin
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		in_valid <= 1'b0;
		cmd <= CMD_TICK;
		jog_count <= '0;
		jog_up <= 1'b0;
		cfg_interval = STEP_INTERVAL_RST;
		cfg_phase = '0;
		cfg_center = '0;
		cfg_amp = '0;
		m_mode = MODE_IDLE;
		m_pos = 0;
		m_up = 1'b1;
		m_armed = 1'b0;
		m_elapsed = '0;
		m_jog_left = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_oscillation_reversal();
		test_jog_extremes();
		stall_tx = 1'b1;
		stall_rx = 1'b1;
		test_register_extremes();
		test_moving_center();
		test_backpressure();
		test_pause_drain();
		test_random_phases();
		drain_results();
		repeat (6) @(posedge clk);
		if (bad_fields == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
